FILE: rtl/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation and status codes, shared-unit opcodes.
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int OperandWidthDefault = 32;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_EQ  = 4'd4,
        CMD_LT  = 4'd5,
        CMD_GT  = 4'd6,
        CMD_LE  = 4'd7,
        CMD_GE  = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERODEN = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_OVF     = 2'd3
    } t_status;

    // shared-unit operations
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1,
        OP_GCD = 2'd2
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_ctl;

endpackage

FILE: rtl/rau_unit.sv
// ---------------------------------------------------------------------------
// rau_unit: shared multicycle arithmetic unit
// Shift-add multiply, restoring divide, binary GCD, one bit step per cycle.
// ---------------------------------------------------------------------------
module rau_unit #(
    parameter int W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_unit_ctl i_ctl,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic [W-1:0]      o_res,
    output logic              o_done
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_a, r_b, r_acc, n_a, n_b, n_acc;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_sh, n_sh;
    logic          r_busy, n_busy, r_done, n_done;
    rau_pkg::t_op  r_op, n_op;
    logic [W:0]    w_rem;
    logic [W-1:0]  w_diff;

    always_comb begin
        n_a = r_a; n_b = r_b; n_acc = r_acc; n_cnt = r_cnt; n_sh = r_sh;
        n_busy = r_busy; n_done = 1'b0; n_op = r_op;
        w_rem = '0;
        w_diff = '0;
        if (i_ctl.start) begin
            n_a = i_a; n_b = i_b; n_acc = '0; n_cnt = CW'(W); n_sh = '0;
            n_busy = 1'b1; n_op = i_ctl.op;
        end else if (r_busy) begin
            case (r_op)
                rau_pkg::OP_MUL: begin
                    if (r_b[0]) n_acc = r_acc + r_a;
                    n_a = r_a << 1;
                    n_b = r_b >> 1;
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin n_busy = 1'b0; n_done = 1'b1; end
                end
                rau_pkg::OP_DIV: begin
                    // r_acc remainder, r_a quotient bits shifted in
                    w_rem = {r_acc, r_a[W-1]};
                    n_a = r_a << 1;
                    if (w_rem >= {1'b0, r_b}) begin
                        w_rem = w_rem - {1'b0, r_b};
                        n_a[0] = 1'b1;
                    end
                    n_acc = w_rem[W-1:0];
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin n_busy = 1'b0; n_done = 1'b1; end
                end
                rau_pkg::OP_GCD: begin
                    if (r_a == '0) begin
                        n_acc = r_b << r_sh; n_busy = 1'b0; n_done = 1'b1;
                    end else if (r_b == '0) begin
                        n_acc = r_a << r_sh; n_busy = 1'b0; n_done = 1'b1;
                    end else if (!r_a[0] && !r_b[0]) begin
                        n_a = r_a >> 1; n_b = r_b >> 1; n_sh = r_sh + 1'b1;
                    end else if (!r_a[0]) begin
                        n_a = r_a >> 1;
                    end else if (!r_b[0]) begin
                        n_b = r_b >> 1;
                    end else if (r_a >= r_b) begin
                        w_diff = r_a - r_b; n_a = w_diff >> 1;
                    end else begin
                        w_diff = r_b - r_a; n_b = w_diff >> 1;
                    end
                end
                default: begin
                    n_busy = 1'b0; n_done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b; r_acc <= n_acc; r_cnt <= n_cnt; r_sh <= n_sh;
        r_op <= n_op;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_res  = (r_op == rau_pkg::OP_DIV) ? r_a : r_acc;
    assign o_done = r_done;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |=> r_busy) else $error("start lost");
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("double done");
endmodule

FILE: rtl/rational_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// rational_arithmetic_unit: reduced rational add/sub/mul/div/compare
// Operands normalized and reduced, result reduced and range checked.
// ---------------------------------------------------------------------------
// Steps: 12 steps on one shared 64-bit unit: six divides, three multiplies
// and three binary GCDs. A zero operand denominator is answered straight
// from idle with status ST_ZERODEN. One item at a time; the next is taken
// once the result leaves the output register. Reset: synchronous active
// low, sequencer idle.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_cmd,
    input  logic signed [31:0] i_lhs_num,
    input  logic signed [31:0] i_lhs_den,
    input  logic signed [31:0] i_rhs_num,
    input  logic signed [31:0] i_rhs_den,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic        o_cmp_true,
    output logic [1:0]  o_status
);
    localparam int UW = 64;
    localparam int OW = OPERAND_WIDTH;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_GA   = 14'b00000000000010,
        S_DAN  = 14'b00000000000100,
        S_DAD  = 14'b00000000001000,
        S_GB   = 14'b00000000010000,
        S_DBN  = 14'b00000000100000,
        S_DBD  = 14'b00000001000000,
        S_M1   = 14'b00000010000000,
        S_M2   = 14'b00000100000000,
        S_M3   = 14'b00001000000000,
        S_GR   = 14'b00010000000000,
        S_DRN  = 14'b00100000000000,
        S_DRD  = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } t_state;

    t_state r_st, n_st;
    logic [3:0]    r_cmd;
    logic          r_sa, r_sb, r_sr;
    logic [UW-1:0] r_an, r_ad, r_bn, r_bd, r_g, r_x, r_y, r_rn, r_rd;
    logic          r_ocmp;
    logic [1:0]    r_ost;
    logic [31:0]   r_onum;
    logic [30:0]   r_oden;
    logic          r_go;

    rau_pkg::t_unit_ctl w_ctl;
    logic [UW-1:0] w_ua, w_ub, w_ures;
    logic          w_udone;

    rau_unit #(.W(UW)) u_unit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_a(w_ua), .i_b(w_ub), .o_res(w_ures), .o_done(w_udone)
    );

    function automatic logic [UW-1:0] f_mag(input logic [31:0] raw);
        logic [OW-1:0] b;
        logic [OW-1:0] nb;
        b = raw[OW-1:0];
        nb = -b;
        f_mag = b[OW-1] ? UW'(nb) : UW'(b);
    endfunction

    function automatic logic f_neg(input logic [31:0] raw);
        f_neg = raw[OW-1];
    endfunction

    logic w_acc_in, w_acc_out;
    logic [UW-1:0] w_lim;
    logic w_xneg, w_yneg, w_c_lt, w_c_eq, w_t, w_ovf, w_rneg;
    logic [UW-1:0] w_rmag;
    logic w_div0, w_cmp_op;

    assign w_lim     = UW'(1) << (OW - 1);
    assign w_acc_in  = i_valid && !o_stall;
    assign w_acc_out = o_valid && !i_stall;
    assign o_stall   = (r_st != S_IDLE) || o_valid;

    // cross products live in r_x (a.n*b.d, a.n*b.n for multiply) and r_y (b.n*a.d)
    assign w_xneg = r_sa && (r_an != '0);
    assign w_yneg = r_sb && (r_bn != '0);
    always_comb begin
        w_c_eq = (w_xneg == w_yneg) && (r_x == r_y);
        if (w_xneg != w_yneg) w_c_lt = w_xneg;
        else if (!w_xneg)     w_c_lt = r_x < r_y;
        else                  w_c_lt = r_x > r_y;
        case (r_cmd)
            rau_pkg::CMD_EQ: w_t = w_c_eq;
            rau_pkg::CMD_LT: w_t = w_c_lt;
            rau_pkg::CMD_GT: w_t = !w_c_lt && !w_c_eq;
            rau_pkg::CMD_LE: w_t = w_c_lt || w_c_eq;
            rau_pkg::CMD_GE: w_t = !w_c_lt;
            default:         w_t = 1'b0;
        endcase
    end

    assign w_rneg = r_sr && (r_rn != '0);
    assign w_rmag = r_rn;
    assign w_ovf  = (w_rneg ? (w_rmag > w_lim) : (w_rmag >= w_lim))
                    || ((r_rn == '0) ? 1'b0 : (r_rd >= w_lim));

    always_comb begin
        n_st = r_st;
        w_ctl.start = 1'b0;
        w_ctl.op = rau_pkg::OP_GCD;
        w_ua = '0;
        w_ub = '0;
        case (r_st)
            S_IDLE: if (w_acc_in && (f_mag(i_lhs_den) != '0)
                        && (f_mag(i_rhs_den) != '0)) n_st = S_GA;
            S_GA:  begin w_ua = r_an; w_ub = r_ad; if (w_udone) n_st = S_DAN; end
            S_DAN: begin w_ua = r_an; w_ub = r_g;  if (w_udone) n_st = S_DAD; end
            S_DAD: begin w_ua = r_ad; w_ub = r_g;  if (w_udone) n_st = S_GB; end
            S_GB:  begin w_ua = r_bn; w_ub = r_bd; if (w_udone) n_st = S_DBN; end
            S_DBN: begin w_ua = r_bn; w_ub = r_g;  if (w_udone) n_st = S_DBD; end
            S_DBD: begin w_ua = r_bd; w_ub = r_g;  if (w_udone) n_st = S_M1; end
            S_M1:  begin w_ua = r_an; w_ub = (r_cmd == rau_pkg::CMD_MUL) ? r_bn : r_bd;
                   if (w_udone) n_st = S_M2; end
            S_M2:  begin w_ua = r_bn; w_ub = r_ad; if (w_udone) n_st = S_M3; end
            S_M3:  begin w_ua = r_ad; w_ub = r_bd; if (w_udone) n_st = S_GR; end
            S_GR:  begin w_ua = r_rn; w_ub = r_rd; if (w_udone) n_st = S_DRN; end
            S_DRN: begin w_ua = r_rn; w_ub = r_g;  if (w_udone) n_st = S_DRD; end
            S_DRD: begin w_ua = r_rd; w_ub = r_g;  if (w_udone) n_st = S_OUT; end
            S_OUT: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
        if (r_st == S_DAN || r_st == S_DAD || r_st == S_DBN || r_st == S_DBD
            || r_st == S_DRN || r_st == S_DRD) w_ctl.op = rau_pkg::OP_DIV;
        if (r_st == S_M1 || r_st == S_M2 || r_st == S_M3) w_ctl.op = rau_pkg::OP_MUL;
        // start on entry to each unit step
        w_ctl.start = (r_st != S_IDLE) && (r_st != S_OUT) && r_go;
    end

    assign w_cmp_op = (r_cmd >= rau_pkg::CMD_EQ);
    assign w_div0   = (r_cmd == rau_pkg::CMD_DIV) && (r_bn == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_go <= 1'b0;
        end else begin
            r_st <= n_st;
            r_go <= (n_st != r_st);
        end
        if (r_st == S_IDLE && w_acc_in) begin
            r_cmd <= i_cmd;
            r_an <= f_mag(i_lhs_num); r_ad <= f_mag(i_lhs_den);
            r_bn <= f_mag(i_rhs_num); r_bd <= f_mag(i_rhs_den);
            r_sa <= f_neg(i_lhs_num) ^ f_neg(i_lhs_den);
            r_sb <= f_neg(i_rhs_num) ^ f_neg(i_rhs_den);
        end
        if (w_udone) begin
            case (r_st)
                S_GA, S_GB, S_GR: r_g <= (w_ures == '0) ? UW'(1) : w_ures;
                S_DAN: r_an <= w_ures;
                S_DAD: r_ad <= (r_an == '0) ? UW'(1) : w_ures;
                S_DBN: r_bn <= w_ures;
                S_DBD: r_bd <= (r_bn == '0) ? UW'(1) : w_ures;
                S_M1:  r_x <= w_ures;
                S_M2:  r_y <= w_ures;
                S_M3:  r_rd <= (r_cmd == rau_pkg::CMD_DIV) ? r_y : w_ures;
                S_DRN: r_rn <= w_ures;
                S_DRD: r_rd <= w_ures;
                default: r_g <= r_g;
            endcase
        end
        if (r_st == S_M3 && w_udone) begin
            // combine numerator from cross products before GCD starts
            case (r_cmd)
                rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                    if (w_xneg == ((r_cmd == rau_pkg::CMD_SUB) ? !w_yneg : w_yneg)) begin
                        r_rn <= r_x + r_y; r_sr <= w_xneg;
                    end else if (r_x >= r_y) begin
                        r_rn <= r_x - r_y; r_sr <= w_xneg;
                    end else begin
                        r_rn <= r_y - r_x; r_sr <= !w_xneg;
                    end
                end
                rau_pkg::CMD_MUL: begin r_rn <= r_x; r_sr <= r_sa ^ r_sb; end
                default: begin r_rn <= r_x; r_sr <= r_sa ^ r_sb; end
            endcase
        end
    end

    // output register
    logic r_ovalid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_st == S_IDLE && w_acc_in &&
                     (f_mag(i_lhs_den) == '0 || f_mag(i_rhs_den) == '0)) begin
            r_ovalid <= 1'b1;
        end else if (r_st == S_OUT) begin
            r_ovalid <= 1'b1;
        end else if (w_acc_out) begin
            r_ovalid <= 1'b0;
        end
        if (r_st == S_IDLE && w_acc_in) begin
            r_onum <= '0; r_oden <= 31'd1; r_ocmp <= 1'b0; r_ost <= rau_pkg::ST_ZERODEN;
        end else if (r_st == S_OUT) begin
            r_onum <= '0; r_oden <= 31'd1; r_ocmp <= 1'b0; r_ost <= rau_pkg::ST_OK;
            if (r_cmd > rau_pkg::CMD_GE) begin
                r_ost <= rau_pkg::ST_OK;
            end else if (w_cmp_op) begin
                r_ocmp <= w_t;
            end else if (w_div0) begin
                r_ost <= rau_pkg::ST_DIVZERO;
            end else if (w_ovf) begin
                r_ost <= rau_pkg::ST_OVF;
            end else begin
                r_onum <= w_rneg ? 32'(-w_rmag) : 32'(w_rmag);
                r_oden <= (r_rn == '0) ? 31'd1 : 31'(r_rd);
            end
        end
    end

    assign o_valid    = r_ovalid;
    assign o_res_num  = r_onum;
    assign o_res_den  = r_oden;
    assign o_cmp_true = r_ocmp;
    assign o_status   = r_ost;

    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE && r_st != S_OUT) |-> !$rose(r_ovalid))
        else $error("result during work");
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |=> o_valid) else $error("result lost");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res_den != '0)) else $error("zero denominator out");
endmodule
